// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SEM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SEM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg
// types and constants of the sobel edge magnitude block
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int unsigned GRAY_W = 8;
  localparam int unsigned COEF_W = 4;
  localparam int unsigned PART_W = 14;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned ROW_W  = 18;

  localparam logic [8:0]  LUMA_R = 9'd299;
  localparam logic [9:0]  LUMA_G = 10'd587;
  localparam logic [6:0]  LUMA_B = 7'd114;
  // ceil(2^28 / 1000), exact floor divide for sums up to 255000
  localparam logic [18:0] RECIP_1000 = 19'd268436;
  localparam int unsigned RECIP_SHIFT = 28;

  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [15:0] HEIGHT_RST = 16'd480;
  localparam logic [35:0] MASK_X_RST = 36'd4548780303;
  localparam logic [35:0] MASK_Y_RST = 36'd4848619503;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MASK_X = 2'd2,
    REG_MASK_Y = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GRAY,
    S_WIN,
    S_CONV,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic       shift;
    logic [2:0] row_ok;
  } cell_ctl_t;

endpackage

// ===== rtl/core/sem_ram.sv =====
// ----------------------------------------------------------------------------
// sem_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sem_win_cell.sv =====
// ----------------------------------------------------------------------------
// sem_win_cell
// one window column: three gray pixels and their weighted partial sums
// ----------------------------------------------------------------------------
module sem_win_cell (
  input  logic                                   clk_i,
  input  sem_pkg::cell_ctl_t                     ctl_i,
  input  logic                                   col_ok_i,
  input  logic [2:0][sem_pkg::GRAY_W-1:0]        pix_i,
  input  logic [2:0][sem_pkg::COEF_W-1:0]        coef_x_i,
  input  logic [2:0][sem_pkg::COEF_W-1:0]        coef_y_i,
  output logic [2:0][sem_pkg::GRAY_W-1:0]        pix_o,
  output logic signed [sem_pkg::PART_W-1:0]      part_x_o,
  output logic signed [sem_pkg::PART_W-1:0]      part_y_o
);

  logic [2:0][sem_pkg::GRAY_W-1:0] pix_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      pix_q <= pix_i;
    end
  end

  always_comb begin
    logic signed [sem_pkg::PART_W-1:0] px;
    logic signed [sem_pkg::PART_W-1:0] cx;
    logic signed [sem_pkg::PART_W-1:0] cy;
    logic signed [sem_pkg::PART_W-1:0] sx;
    logic signed [sem_pkg::PART_W-1:0] sy;
    sx = '0;
    sy = '0;
    for (int r = 0; r < 3; r++) begin
      px = $signed({6'b0, pix_q[r]});
      cx = $signed({{10{coef_x_i[r][3]}}, coef_x_i[r]});
      cy = $signed({{10{coef_y_i[r][3]}}, coef_y_i[r]});
      if (col_ok_i && ctl_i.row_ok[r]) begin
        sx = sx + px * cx;
        sy = sy + px * cy;
      end
    end
    part_x_o = sx;
    part_y_o = sy;
  end

  assign pix_o = pix_q;

endmodule

// ===== rtl/core/sem_isqrt.sv =====
// ----------------------------------------------------------------------------
// sem_isqrt
// iterative floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
module sem_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [17:0] radicand_i,
  output logic        busy_o,
  output logic [8:0]  root_o
);

  logic [17:0] rad_q;
  logic [9:0]  rem_q;
  logic [8:0]  root_q;
  logic [3:0]  cnt_q;
  logic [11:0] rem_sh;
  logic [11:0] trial;

  assign rem_sh = {rem_q, rad_q[17:16]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 4'd9;
    end else if (cnt_q != 4'd0) begin
      cnt_q <= cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != 4'd0) begin
      rad_q <= {rad_q[15:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= 10'(rem_sh - trial);
        root_q <= {root_q[7:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[9:0];
        root_q <= {root_q[7:0], 1'b0};
      end
    end
  end

  assign busy_o = (cnt_q != 4'd0);
  assign root_o = root_q;

endmodule

// ===== rtl/core/sobel_edge_magnitude.sv =====
// processing: gray divide, window shift and convolution for every item, then
// for an item that gives a result the iterative square root at one bit per
// cycle and the load of the result register
// throughput: one item at a time; the next is taken once the previous item
// ends without a result or its result sits in the output register
// reset: asynchronous active low; clears control state and config registers
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// streaming 3x3 gradient magnitude over gray converted rgb pixels
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        pad_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  magnitude_o,
  output logic [7:0]  grad_x_o,
  output logic [7:0]  grad_y_o,
  output logic        frame_last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = sem_pkg::ROW_W;

  // configuration
  logic [11:0] width_q;
  logic [15:0] height_q;
  logic [35:0] mask_x_q;
  logic [35:0] mask_y_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sem_pkg::WIDTH_RST;
      height_q <= sem_pkg::HEIGHT_RST;
      mask_x_q <= sem_pkg::MASK_X_RST;
      mask_y_q <= sem_pkg::MASK_Y_RST;
    end else if (cfg_we) begin
      unique case (sem_pkg::reg_idx_e'(paddr[4:3]))
        sem_pkg::REG_WIDTH:  width_q  <= pwdata[11:0];
        sem_pkg::REG_HEIGHT: height_q <= pwdata[15:0];
        sem_pkg::REG_MASK_X: mask_x_q <= pwdata[35:0];
        sem_pkg::REG_MASK_Y: mask_y_q <= pwdata[35:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sem_pkg::reg_idx_e'(paddr[4:3]))
      sem_pkg::REG_WIDTH:  prdata = {52'b0, width_q};
      sem_pkg::REG_HEIGHT: prdata = {48'b0, height_q};
      sem_pkg::REG_MASK_X: prdata = {28'b0, mask_x_q};
      sem_pkg::REG_MASK_Y: prdata = {28'b0, mask_y_q};
      default:             prdata = '0;
    endcase
  end

  // effective frame size
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  always_comb begin
    if (width_q == 12'd0) begin
      w_eff = CW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_q);
    end
    h_eff = (height_q == 16'd0) ? RW'(1) : RW'(height_q);
  end

  // state machine
  sem_pkg::state_e state_q, state_d;
  logic emit_q;
  logic sqrt_busy;
  logic out_free;
  logic accept;
  logic st_shift, st_root_go, st_load;
  logic out_valid_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sem_pkg::S_IDLE:      if (in_valid_i) state_d = sem_pkg::S_GRAY;
      sem_pkg::S_GRAY:      state_d = sem_pkg::S_WIN;
      sem_pkg::S_WIN:       state_d = sem_pkg::S_CONV;
      sem_pkg::S_CONV:      state_d = emit_q ? sem_pkg::S_ROOT_GO : sem_pkg::S_IDLE;
      sem_pkg::S_ROOT_GO:   state_d = sem_pkg::S_ROOT_WAIT;
      sem_pkg::S_ROOT_WAIT: if (!sqrt_busy) state_d = sem_pkg::S_OUT;
      sem_pkg::S_OUT:       if (out_free) state_d = sem_pkg::S_IDLE;
      default:              state_d = sem_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    st_shift   = 1'b0;
    st_root_go = 1'b0;
    st_load    = 1'b0;
    unique case (state_q)
      sem_pkg::S_IDLE:    in_ready_o = 1'b1;
      sem_pkg::S_WIN:     st_shift   = 1'b1;
      sem_pkg::S_ROOT_GO: st_root_go = 1'b1;
      sem_pkg::S_OUT:     st_load    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sem_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // position normalize at the transaction
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_a;
  logic [RW-1:0] row_a;

  always_comb begin
    col_a = col_q;
    row_a = row_q;
    if (col_q >= w_eff) begin
      col_a = '0;
      row_a = row_q + RW'(1);
    end
    if (row_a > h_eff + RW'(1)) begin
      row_a = '0;
      col_a = '0;
    end
  end

  // gray conversion
  logic [17:0] wsum_q;
  logic [7:0]  gray_q;
  logic [7:0]  top_q, mid_q;
  logic [36:0] gray_prod;
  logic [7:0]  top_rd, mid_rd;

  assign gray_prod = 37'(wsum_q) * 37'(sem_pkg::RECIP_1000);

  // line stores
  logic [AW-1:0] raddr;
  assign raddr = (state_q == sem_pkg::S_IDLE) ? col_a[AW-1:0] : col_q[AW-1:0];

  sem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_top_ram (
    .clk_i   (clk_i),
    .we_i    (st_shift),
    .waddr_i (col_q[AW-1:0]),
    .wdata_i (mid_q),
    .raddr_i (raddr),
    .rdata_o (top_rd)
  );

  sem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_mid_ram (
    .clk_i   (clk_i),
    .we_i    (st_shift),
    .waddr_i (col_q[AW-1:0]),
    .wdata_i (gray_q),
    .raddr_i (raddr),
    .rdata_o (mid_rd)
  );

  // window position of the center pixel
  logic signed [RW:0] cr;
  logic [CW-1:0]      cc;
  logic top_ok_q, bot_ok_q, l_ok_q, r_ok_q, last_q;

  always_comb begin
    if (col_q != '0) begin
      cr = $signed({1'b0, row_q}) - $signed((RW+1)'(1));
      cc = col_q - CW'(1);
    end else begin
      cr = $signed({1'b0, row_q}) - $signed((RW+1)'(2));
      cc = w_eff - CW'(1);
    end
  end

  // window cells
  sem_pkg::cell_ctl_t                 cell_ctl;
  logic [2:0][2:0][7:0]               pix_in, pix_out;
  logic [2:0]                         col_ok;
  logic signed [sem_pkg::PART_W-1:0]  part_x [3];
  logic signed [sem_pkg::PART_W-1:0]  part_y [3];

  assign cell_ctl.shift  = st_shift;
  assign cell_ctl.row_ok = {bot_ok_q, 1'b1, top_ok_q};
  assign col_ok          = {r_ok_q, 1'b1, l_ok_q};

  for (genvar j = 0; j < 3; j++) begin : g_cell
    logic [2:0][3:0] cx, cy;
    for (genvar i = 0; i < 3; i++) begin : g_coef
      assign cx[i] = mask_x_q[4*(3*i+j) +: 4];
      assign cy[i] = mask_y_q[4*(3*i+j) +: 4];
    end
    if (j == 2) begin : g_head
      assign pix_in[j] = {gray_q, mid_q, top_q};
    end else begin : g_link
      assign pix_in[j] = pix_out[j+1];
    end
    sem_win_cell u_cell (
      .clk_i    (clk_i),
      .ctl_i    (cell_ctl),
      .col_ok_i (col_ok[j]),
      .pix_i    (pix_in[j]),
      .coef_x_i (cx),
      .coef_y_i (cy),
      .pix_o    (pix_out[j]),
      .part_x_o (part_x[j]),
      .part_y_o (part_y[j])
    );
  end

  logic signed [sem_pkg::SUM_W-1:0] gx, gy;
  logic [7:0] ux_q, uy_q, ux_c, uy_c;

  assign gx = sem_pkg::SUM_W'(part_x[0]) + sem_pkg::SUM_W'(part_x[1])
            + sem_pkg::SUM_W'(part_x[2]);
  assign gy = sem_pkg::SUM_W'(part_y[0]) + sem_pkg::SUM_W'(part_y[1])
            + sem_pkg::SUM_W'(part_y[2]);

  always_comb begin
    if (gx < 0) ux_c = '0;
    else if (gx > 16'sd255) ux_c = 8'd255;
    else ux_c = gx[7:0];
    if (gy < 0) uy_c = '0;
    else if (gy > 16'sd255) uy_c = 8'd255;
    else uy_c = gy[7:0];
  end

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      emit_q <= 1'b0;
    end else begin
      unique case (state_q)
        sem_pkg::S_IDLE: begin
          if (accept) begin
            col_q <= col_a;
            row_q <= row_a;
          end
        end
        sem_pkg::S_WIN: begin
          emit_q <= (cr >= 0) && (cr < $signed({1'b0, h_eff}));
          if (col_q + CW'(1) >= w_eff) begin
            col_q <= '0;
            row_q <= row_q + RW'(1);
          end else begin
            col_q <= col_q + CW'(1);
          end
        end
        sem_pkg::S_CONV: begin
          if (emit_q && last_q) begin
            col_q <= '0;
            row_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (pad_i || row_a >= h_eff) begin
        wsum_q <= '0;
      end else begin
        wsum_q <= 18'(sem_pkg::LUMA_R) * 18'(red_i)
                + 18'(sem_pkg::LUMA_G) * 18'(green_i)
                + 18'(sem_pkg::LUMA_B) * 18'(blue_i);
      end
    end
    if (state_q == sem_pkg::S_GRAY) begin
      gray_q <= gray_prod[sem_pkg::RECIP_SHIFT +: 8];
      top_q  <= top_rd;
      mid_q  <= mid_rd;
    end
    if (st_shift) begin
      top_ok_q <= (cr >= $signed((RW+1)'(1)));
      bot_ok_q <= (cr != $signed({1'b0, h_eff}) - $signed((RW+1)'(1)));
      l_ok_q   <= (cc != '0);
      r_ok_q   <= (cc != w_eff - CW'(1));
      last_q   <= (cr == $signed({1'b0, h_eff}) - $signed((RW+1)'(1)))
               && (cc == w_eff - CW'(1));
    end
    if (state_q == sem_pkg::S_CONV) begin
      ux_q <= ux_c;
      uy_q <= uy_c;
    end
  end

  // magnitude
  logic [17:0] radicand;
  logic [8:0]  root;

  assign radicand = 18'(16'(ux_q) * 16'(ux_q)) + 18'(16'(uy_q) * 16'(uy_q));

  sem_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (st_root_go),
    .radicand_i (radicand),
    .busy_o     (sqrt_busy),
    .root_o     (root)
  );

  // output register
  logic [7:0] mag_q, gxo_q, gyo_q;
  logic       flast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_load) begin
      mag_q   <= (root > 9'd255) ? 8'd255 : root[7:0];
      gxo_q   <= ux_q;
      gyo_q   <= uy_q;
      flast_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign magnitude_o  = mag_q;
  assign grad_x_o     = gxo_q;
  assign grad_y_o     = gyo_q;
  assign frame_last_o = flast_q;

endmodule

// ===== rtl/core/sem_checker.sv =====
// ----------------------------------------------------------------------------
// sem_checker
// port level checks of the sobel edge magnitude block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sem_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] magnitude_o,
  input logic [7:0] grad_x_o,
  input logic [7:0] grad_y_o,
  input logic       pready
);

  `SEM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `SEM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(magnitude_o))
  `SEM_ASSERT_IMPL(a_mag_ge, clk_i, rst_ni, out_valid_o, magnitude_o >= grad_x_o && magnitude_o >= grad_y_o)
  `SEM_ASSERT_IMPL(a_mag_axis, clk_i, rst_ni, out_valid_o && grad_x_o == 8'd0, magnitude_o == grad_y_o)
  `SEM_ASSERT_IMPL(a_pready, clk_i, rst_ni, 1'b1, pready)

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (.*);
